// ----- design/r2mv_pkg.sv -----
// ----------------------------------------------------------------------------
// r2mv_pkg
// Shared constants for the rank-two update and matrix-vector block: sizes,
// fixed-point widths, command codes, result kinds, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package r2mv_pkg;

  // Largest vector length and the address widths that follow from it.
  localparam int MAX_LENGTH = 64;
  localparam int IDX_W      = $clog2(MAX_LENGTH);
  localparam int MAT_AW     = 2 * IDX_W;
  localparam int MAT_DEPTH  = 1 << MAT_AW;

  // Field widths of the transactions.
  localparam int CMD_W   = 2;
  localparam int INDEX_W = 6;
  localparam int VEC_W   = 16;
  localparam int LEN_W   = 7;
  localparam int A_W     = 32;
  localparam int W_W     = 48;

  // Datapath widths.
  localparam int FRAC_SH = 10;
  localparam int PROD_W  = 2 * VEC_W;
  localparam int SUMA_W  = A_W + 2;
  localparam int MAC_W   = A_W + VEC_W;
  localparam int ACC_W   = MAC_W + IDX_W + 1;
  localparam int S_W     = ACC_W - FRAC_SH;
  localparam int AP_W    = S_W + VEC_W;
  localparam int T_W     = AP_W - FRAC_SH;
  localparam int WS_W    = T_W + 1;
  localparam int W0_W    = PROD_W + 1;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

  // Result kinds.
  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ALPHA = 2'd0;
  localparam logic [1:0] CFG_BETA  = 2'd1;
  localparam logic [1:0] CFG_LEN   = 2'd2;

  // Register reset values.
  localparam logic [VEC_W-1:0] ALPHA_RST = 16'd236;
  localparam logic [VEC_W-1:0] BETA_RST  = 16'd461;
  localparam logic [LEN_W-1:0] LEN_RST   = 7'd64;

endpackage

`default_nettype wire

// ----- design/r2mv_ram.sv -----
// ----------------------------------------------------------------------------
// r2mv_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module r2mv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/rank2_update_and_matvec.sv -----
// ----------------------------------------------------------------------------
// rank2_update_and_matvec
// Fixed-point rank-two matrix update followed by a matrix-vector product.
// The matrix, the vectors and w live in synchronous RAMs; a sequencer reads,
// updates and writes back one matrix element at a time.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Contents
// in_       slave      in_tvalid/in_tready  tuser: command; tdata: index, u1, u2, v1, v2
// out_      master     out_tvalid/out_tready tuser: result kind; tdata: w value, saturated
// cfg_      write      cfg_we               cfg_addr selects alpha, beta or length
//
// After reset the block sweeps the matrix and w to zero and takes no transaction
// meanwhile. A run does one read-modify-write of the matrix RAM per element,
// done in five steps. A result waits in the output register; a second result
// waits until it is taken.

`default_nettype none

module rank2_update_and_matvec (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input: tdata = index, u1_value, u2_value, v1_value, v2_value, zero pad
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,
  input  wire logic [1:0]  in_tuser,  // command
  // Output: tdata = w_value, saturated, zero pad
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,
  output logic [0:0]       out_tuser, // result_kind
  // Configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  localparam int IDX_W  = r2mv_pkg::IDX_W;
  localparam int VEC_W  = r2mv_pkg::VEC_W;
  localparam int LEN_W  = r2mv_pkg::LEN_W;
  localparam int A_W    = r2mv_pkg::A_W;
  localparam int W_W    = r2mv_pkg::W_W;
  localparam int MAT_AW = r2mv_pkg::MAT_AW;
  localparam int FSH    = r2mv_pkg::FRAC_SH;

  // Sequencer states.
  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RDW  = 4'd2;
  localparam logic [3:0] S_ROW0 = 4'd3;
  localparam logic [3:0] S_ROW1 = 4'd4;
  localparam logic [3:0] S_COL0 = 4'd5;
  localparam logic [3:0] S_COL1 = 4'd6;
  localparam logic [3:0] S_COL2 = 4'd7;
  localparam logic [3:0] S_COL3 = 4'd8;
  localparam logic [3:0] S_COL4 = 4'd9;
  localparam logic [3:0] S_END0 = 4'd10;
  localparam logic [3:0] S_END1 = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  // Input field split.
  logic [r2mv_pkg::CMD_W-1:0]   in_cmd;
  logic [r2mv_pkg::INDEX_W-1:0] in_idx;
  logic                         in_idx_ok;
  logic                         in_acc;
  assign in_cmd    = in_tuser;
  assign in_idx    = in_tdata[5:0];
  assign in_idx_ok = (32'(in_idx) < r2mv_pkg::MAX_LENGTH);
  assign in_acc    = in_tvalid && in_tready;

  // Control registers.
  logic [3:0]        state_r;
  logic [MAT_AW-1:0] clr_cnt_r;
  logic              clr_w_r;
  logic [IDX_W-1:0]  i_r;
  logic [IDX_W-1:0]  j_r;
  logic [LEN_W-1:0]  len_r;
  logic              sat_r;
  logic              rd_ok_r;
  logic              out_valid_r;

  // Configuration registers.
  logic signed [VEC_W-1:0] alpha_r;
  logic signed [VEC_W-1:0] beta_r;
  logic [LEN_W-1:0]        len_cfg_r;

  // Datapath registers.
  logic signed [VEC_W-1:0]               u1i_r;
  logic signed [VEC_W-1:0]               u2i_r;
  logic signed [VEC_W-1:0]               u1j_r;
  logic signed [A_W-1:0]                 a_old_r;
  logic signed [r2mv_pkg::PROD_W-1:0]    p1_r;
  logic signed [r2mv_pkg::PROD_W-1:0]    p2_r;
  logic signed [A_W-1:0]                 a_sat_r;
  logic signed [r2mv_pkg::MAC_W-1:0]     mac_r;
  logic signed [r2mv_pkg::ACC_W-1:0]     acc_r;
  logic signed [r2mv_pkg::W0_W-1:0]      w0_r;
  logic signed [r2mv_pkg::AP_W-1:0]      ap_r;
  logic                                  res_kind_r;
  logic signed [W_W-1:0]                 res_w_r;
  logic                                  out_kind_r;
  logic signed [W_W-1:0]                 out_w_r;
  logic                                  out_sat_r;

  // Memory ports.
  logic              vec_we;
  logic [IDX_W-1:0]  vec_raddr;
  logic [63:0]       vec_rdata;
  logic              mat_we;
  logic [MAT_AW-1:0] mat_waddr;
  logic [A_W-1:0]    mat_wdata;
  logic [A_W-1:0]    mat_rdata;
  logic              w_we;
  logic [IDX_W-1:0]  w_waddr;
  logic [W_W-1:0]    w_wdata;
  logic [IDX_W-1:0]  w_raddr;
  logic [W_W-1:0]    w_rdata;

  // Vector elements of the word read this cycle.
  logic signed [VEC_W-1:0] rd_u1;
  logic signed [VEC_W-1:0] rd_u2;
  logic signed [VEC_W-1:0] rd_v1;
  logic signed [VEC_W-1:0] rd_v2;
  assign rd_u1 = vec_rdata[15:0];
  assign rd_u2 = vec_rdata[31:16];
  assign rd_v1 = vec_rdata[47:32];
  assign rd_v2 = vec_rdata[63:48];

  // Arithmetic.
  logic signed [r2mv_pkg::PROD_W-1:0] p1_nxt;
  logic signed [r2mv_pkg::PROD_W-1:0] p2_nxt;
  logic signed [r2mv_pkg::SUMA_W-1:0] suma;
  logic                               suma_ovf;
  logic signed [A_W-1:0]              a_sat_nxt;
  logic signed [r2mv_pkg::MAC_W-1:0]  mac_nxt;
  logic signed [r2mv_pkg::PROD_W-1:0] au_prod;
  logic signed [r2mv_pkg::W0_W-1:0]   w0_nxt;
  logic signed [r2mv_pkg::S_W-1:0]    s_val;
  logic signed [r2mv_pkg::AP_W-1:0]   ap_nxt;
  logic signed [r2mv_pkg::T_W-1:0]    t_val;
  logic signed [r2mv_pkg::WS_W-1:0]   ws;
  logic                               ws_ovf;
  logic signed [W_W-1:0]              w_sat;
  logic [LEN_W-1:0]                   len_eff;
  logic                               last_i;
  logic                               last_j;

  assign p1_nxt = u1i_r * rd_v1;
  assign p2_nxt = u2i_r * rd_v2;

  // Matrix element update with saturation to 32 bits.
  assign suma = r2mv_pkg::SUMA_W'(a_old_r) + r2mv_pkg::SUMA_W'(p1_r)
              + r2mv_pkg::SUMA_W'(p2_r);
  assign suma_ovf = (suma[r2mv_pkg::SUMA_W-1:A_W-1] != '0) &&
                    (suma[r2mv_pkg::SUMA_W-1:A_W-1] != '1);
  always_comb begin
    if (!suma_ovf) begin
      a_sat_nxt = suma[A_W-1:0];
    end else if (suma[r2mv_pkg::SUMA_W-1]) begin
      a_sat_nxt = {1'b1, {(A_W-1){1'b0}}};
    end else begin
      a_sat_nxt = {1'b0, {(A_W-1){1'b1}}};
    end
  end

  assign mac_nxt = a_sat_r * u1j_r;

  // Row start value alpha*u1[i] + beta, in Q.20.
  assign au_prod = alpha_r * rd_u1;
  assign w0_nxt  = r2mv_pkg::W0_W'(au_prod)
                 + r2mv_pkg::W0_W'($signed({beta_r, {FSH{1'b0}}}));

  // Row end: scale the dot product by alpha and saturate w to 48 bits.
  assign s_val  = acc_r[r2mv_pkg::ACC_W-1:FSH];
  assign ap_nxt = alpha_r * s_val;
  assign t_val  = ap_r[r2mv_pkg::AP_W-1:FSH];
  assign ws     = r2mv_pkg::WS_W'(w0_r) + r2mv_pkg::WS_W'(t_val);
  assign ws_ovf = (ws[r2mv_pkg::WS_W-1:W_W-1] != '0) &&
                  (ws[r2mv_pkg::WS_W-1:W_W-1] != '1);
  always_comb begin
    if (!ws_ovf) begin
      w_sat = ws[W_W-1:0];
    end else if (ws[r2mv_pkg::WS_W-1]) begin
      w_sat = {1'b1, {(W_W-1){1'b0}}};
    end else begin
      w_sat = {1'b0, {(W_W-1){1'b1}}};
    end
  end

  assign len_eff = (len_cfg_r > LEN_W'(r2mv_pkg::MAX_LENGTH)) ?
                   LEN_W'(r2mv_pkg::MAX_LENGTH) : len_cfg_r;
  assign last_i  = (LEN_W'(i_r) + LEN_W'(1)) == len_r;
  assign last_j  = (LEN_W'(j_r) + LEN_W'(1)) == len_r;

  // Memory addressing.
  assign vec_we    = in_acc && (in_cmd == r2mv_pkg::CMD_LOAD) && in_idx_ok;
  assign vec_raddr = (state_r == S_ROW0) ? i_r : j_r;
  assign mat_we    = (state_r == S_CLR) || (state_r == S_COL2);
  assign mat_waddr = (state_r == S_CLR) ? clr_cnt_r : {i_r, j_r};
  assign mat_wdata = (state_r == S_CLR) ? '0 : a_sat_nxt;
  assign w_we      = ((state_r == S_CLR) && clr_w_r &&
                      (clr_cnt_r < MAT_AW'(r2mv_pkg::MAX_LENGTH))) ||
                     (state_r == S_END1);
  assign w_waddr   = (state_r == S_CLR) ? clr_cnt_r[IDX_W-1:0] : i_r;
  assign w_wdata   = (state_r == S_CLR) ? '0 : w_sat;
  assign w_raddr   = in_idx[IDX_W-1:0];

  r2mv_ram #(.WIDTH(64), .DEPTH(r2mv_pkg::MAX_LENGTH)) u_vec_ram (
    .clk   (clk),
    .we    (vec_we),
    .waddr (in_idx[IDX_W-1:0]),
    .wdata ({in_tdata[69:54], in_tdata[53:38], in_tdata[37:22], in_tdata[21:6]}),
    .raddr (vec_raddr),
    .rdata (vec_rdata)
  );

  r2mv_ram #(.WIDTH(A_W), .DEPTH(r2mv_pkg::MAT_DEPTH)) u_mat_ram (
    .clk   (clk),
    .we    (mat_we),
    .waddr (mat_waddr),
    .wdata (mat_wdata),
    .raddr ({i_r, j_r}),
    .rdata (mat_rdata)
  );

  r2mv_ram #(.WIDTH(W_W), .DEPTH(r2mv_pkg::MAX_LENGTH)) u_w_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r   <= r2mv_pkg::ALPHA_RST;
      beta_r    <= r2mv_pkg::BETA_RST;
      len_cfg_r <= r2mv_pkg::LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        r2mv_pkg::CFG_ALPHA: alpha_r   <= cfg_wdata;
        r2mv_pkg::CFG_BETA:  beta_r    <= cfg_wdata;
        r2mv_pkg::CFG_LEN:   len_cfg_r <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      clr_w_r     <= 1'b1;
      i_r         <= '0;
      j_r         <= '0;
      len_r       <= '0;
      sat_r       <= 1'b0;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // A taken result is dropped unless a new one replaces it this cycle.
      if (out_valid_r && out_tready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + MAT_AW'(1);
          if (clr_cnt_r == '1) begin
            clr_w_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            unique case (in_cmd)
              r2mv_pkg::CMD_RUN: begin
                sat_r      <= 1'b0;
                len_r      <= len_eff;
                i_r        <= '0;
                res_kind_r <= r2mv_pkg::KIND_DONE;
                res_w_r    <= '0;
                state_r    <= (len_eff == '0) ? S_OUT : S_ROW0;
              end
              r2mv_pkg::CMD_READ: begin
                rd_ok_r <= in_idx_ok;
                state_r <= S_RDW;
              end
              r2mv_pkg::CMD_CLEAR: begin
                clr_cnt_r <= '0;
                state_r   <= S_CLR;
              end
              default: ;
            endcase
          end
        end
        S_RDW: begin
          res_kind_r <= r2mv_pkg::KIND_READ;
          res_w_r    <= rd_ok_r ? w_rdata : '0;
          state_r    <= S_OUT;
        end
        S_ROW0: begin
          j_r     <= '0;
          acc_r   <= '0;
          state_r <= S_ROW1;
        end
        S_ROW1: begin
          u1i_r   <= rd_u1;
          u2i_r   <= rd_u2;
          w0_r    <= w0_nxt;
          state_r <= S_COL0;
        end
        S_COL0: begin
          state_r <= S_COL1;
        end
        S_COL1: begin
          p1_r    <= p1_nxt;
          p2_r    <= p2_nxt;
          a_old_r <= mat_rdata;
          u1j_r   <= rd_u1;
          state_r <= S_COL2;
        end
        S_COL2: begin
          a_sat_r <= a_sat_nxt;
          if (suma_ovf) begin
            sat_r <= 1'b1;
          end
          state_r <= S_COL3;
        end
        S_COL3: begin
          mac_r   <= mac_nxt;
          state_r <= S_COL4;
        end
        S_COL4: begin
          acc_r <= acc_r + r2mv_pkg::ACC_W'(mac_r);
          if (last_j) begin
            state_r <= S_END0;
          end else begin
            j_r     <= j_r + IDX_W'(1);
            state_r <= S_COL0;
          end
        end
        S_END0: begin
          ap_r    <= ap_nxt;
          state_r <= S_END1;
        end
        S_END1: begin
          if (ws_ovf) begin
            sat_r <= 1'b1;
          end
          if (last_i) begin
            state_r <= S_OUT;
          end else begin
            i_r     <= i_r + IDX_W'(1);
            state_r <= S_ROW0;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_kind_r  <= res_kind_r;
            out_w_r     <= res_w_r;
            out_sat_r   <= sat_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Ports.
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_sat_r, out_w_r};
  assign out_tuser  = out_kind_r;

endmodule

`default_nettype wire
